FILE: src/imra_pkg.sv
// Shared constants, types and opcodes for the int8 matrix row accumulate unit.
`default_nettype none
package imra_pkg;

	// Storage sizing
	localparam int MAX_INPUTS  = 256;
	localparam int MAX_OUTPUTS = 64;

	localparam int COL_W   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int ROW_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int WDEPTH  = MAX_OUTPUTS * MAX_INPUTS;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	// Fixed field widths of the channels and registers
	localparam int OP_W    = 2;
	localparam int ROWF_W  = 6;
	localparam int COLF_W  = 8;
	localparam int VAL_W   = 8;
	localparam int ACC_W   = 24;
	localparam int OIDX_W  = 6;
	localparam int LEN_W   = 9;
	localparam int CNT_W   = 7;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Product and full-width sum
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = PROD_W + COL_W + 1;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
	localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_W = 2'd0,
		OP_LOAD_A = 2'd1,
		OP_RUN    = 2'd2
	} imra_op_t;

	// Register numbers, selected by paddr[2]
	typedef enum logic {
		REG_INPUT_LENGTH = 1'b0,
		REG_OUTPUT_COUNT = 1'b1
	} imra_reg_t;

	// Controller to datapath
	typedef struct packed {
		logic             w_we;
		logic             a_we;
		logic             rd;
		logic             first;
		logic             last_k;
		logic             last_row;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] data;
	} imra_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic row_done;
		logic out_free;
	} imra_stat_t;

endpackage
`default_nettype wire

FILE: src/imra_if.sv
// Handshake channel interfaces: command items in, row results out.
`default_nettype none
interface imra_cmd_if;
	import imra_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [ROWF_W-1:0]        row_index;
	logic [COLF_W-1:0]        col_index;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, operation, row_index, col_index, value, input ready);
	modport sink   (input valid, operation, row_index, col_index, value, output ready);
endinterface

interface imra_res_if;
	import imra_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ACC_W-1:0]  accumulator;
	logic [OIDX_W-1:0]        out_index;
	logic                     last;

	modport source (output valid, accumulator, out_index, last, input ready);
	modport sink   (input valid, accumulator, out_index, last, output ready);
endinterface
`default_nettype wire

FILE: src/imra_cfg.sv
// APB register file: input_length and output_count, with clamped last indices.
`default_nettype none
module imra_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [imra_pkg::APB_AW-1:0]   paddr,
	input  wire logic [imra_pkg::APB_DW-1:0]   pwdata,
	output logic      [imra_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [imra_pkg::COL_W-1:0]    last_col,
	output logic      [imra_pkg::ROW_W-1:0]    last_row
);
	import imra_pkg::*;

	logic [LEN_W-1:0] input_length_q;
	logic [CNT_W-1:0] output_count_q;
	logic             wr_en;
	imra_reg_t        sel;

	// clamp to 1..MAX, returned as the highest index
	function automatic logic [COL_W-1:0] clamp_col(input logic [LEN_W-1:0] len);
		if (len == '0)
			return '0;
		if (int'(len) >= MAX_INPUTS)
			return COL_W'(MAX_INPUTS - 1);
		return COL_W'(len - 1'b1);
	endfunction

	function automatic logic [ROW_W-1:0] clamp_row(input logic [CNT_W-1:0] cnt);
		if (cnt == '0)
			return '0;
		if (int'(cnt) >= MAX_OUTPUTS)
			return ROW_W'(MAX_OUTPUTS - 1);
		return ROW_W'(cnt - 1'b1);
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign sel    = imra_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_length_q <= LEN_RESET;
			output_count_q <= CNT_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_INPUT_LENGTH: input_length_q <= pwdata[LEN_W-1:0];
				REG_OUTPUT_COUNT: output_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_INPUT_LENGTH: prdata = APB_DW'(input_length_q);
			REG_OUTPUT_COUNT: prdata = APB_DW'(output_count_q);
			default:          prdata = '0;
		endcase
	end

	assign last_col = clamp_col(input_length_q);
	assign last_row = clamp_row(output_count_q);

endmodule
`default_nettype wire

FILE: src/imra_ctrl.sv
// Controller: accepts items, issues store writes and sequences the row/column sweep.
`default_nettype none
module imra_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	imra_cmd_if.sink                         cmd,
	input  wire logic [imra_pkg::COL_W-1:0]  last_col,
	input  wire logic [imra_pkg::ROW_W-1:0]  last_row,
	input  wire imra_pkg::imra_stat_t        stat,
	output imra_pkg::imra_cmd_t              dp_cmd
);
	import imra_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HOLD,
		S_ISSUE,
		S_DRAIN
	} state_t;

	state_t           state_q;
	imra_cmd_t        cmd_q;
	logic [COL_W-1:0] k_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] last_k_q;
	logic [ROW_W-1:0] last_row_q;
	logic             accept;
	logic             col_ok;
	logic             row_ok;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign col_ok    = int'(cmd.col_index) <= int'(last_col);
	assign row_ok    = int'(cmd.row_index) <= int'(last_row);
	assign dp_cmd    = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			k_q        <= '0;
			row_q      <= '0;
			last_k_q   <= '0;
			last_row_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// store strobes last one cycle; out-of-range loads raise none
					cmd_q.w_we <= accept && (cmd.operation == OP_LOAD_W) && col_ok && row_ok;
					cmd_q.a_we <= accept && (cmd.operation == OP_LOAD_A) && col_ok;
					cmd_q.rd   <= 1'b0;
					if (accept) begin
						cmd_q.row  <= ROW_W'(cmd.row_index);
						cmd_q.col  <= COL_W'(cmd.col_index);
						cmd_q.data <= cmd.value;
						if (cmd.operation == OP_RUN) begin
							last_k_q   <= last_col;
							last_row_q <= last_row;
							k_q        <= '0;
							row_q      <= '0;
							state_q    <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					cmd_q.w_we <= 1'b0;
					cmd_q.a_we <= 1'b0;
					cmd_q.rd   <= 1'b0;
					// wait until the result register can take this row
					if (stat.out_free)
						state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					cmd_q.w_we     <= 1'b0;
					cmd_q.a_we     <= 1'b0;
					cmd_q.rd       <= 1'b1;
					cmd_q.row      <= row_q;
					cmd_q.col      <= k_q;
					cmd_q.first    <= (k_q == '0);
					cmd_q.last_k   <= (k_q == last_k_q);
					cmd_q.last_row <= (row_q == last_row_q);
					if (k_q == last_k_q)
						state_q <= S_DRAIN;
					else
						k_q <= k_q + 1'b1;
				end
				S_DRAIN: begin
					cmd_q.w_we <= 1'b0;
					cmd_q.a_we <= 1'b0;
					cmd_q.rd   <= 1'b0;
					if (stat.row_done) begin
						if (row_q == last_row_q) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							k_q     <= '0;
							state_q <= S_HOLD;
						end
					end
				end
				default: begin
					cmd_q.w_we <= 1'b0;
					cmd_q.a_we <= 1'b0;
					cmd_q.rd   <= 1'b0;
					state_q    <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/imra_dp.sv
// Datapath: weight and activation stores, MAC pipeline, result register.
`default_nettype none
module imra_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire imra_pkg::imra_cmd_t   dp_cmd,
	imra_res_if.source                 res,
	output imra_pkg::imra_stat_t       stat
);
	import imra_pkg::*;

	localparam int EXT_W = (SUM_W > ACC_W) ? SUM_W : ACC_W;
	localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((2 ** (ACC_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

	logic [VAL_W-1:0]        wmem [WDEPTH];
	logic [VAL_W-1:0]        amem [MAX_INPUTS];
	logic [WADDR_W-1:0]      waddr;

	logic                    rd_s1, rd_s2;
	logic                    first_s1, first_s2;
	logic                    lastk_s1, lastk_s2;
	logic                    lastr_s1, lastr_s2;
	logic [ROW_W-1:0]        row_s1, row_s2;
	logic signed [VAL_W-1:0] w_s1, a_s1;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] acc_next;
	logic                    land;

	logic                    out_valid_q;
	logic [ACC_W-1:0]        out_acc_q;
	logic [OIDX_W-1:0]       out_idx_q;
	logic                    out_last_q;

	function automatic logic [ACC_W-1:0] sat(input logic signed [SUM_W-1:0] x);
		logic signed [EXT_W-1:0] xe;
		xe = EXT_W'(x);
		if (xe > SAT_HI)
			return ACC_W'(SAT_HI);
		if (xe < SAT_LO)
			return ACC_W'(SAT_LO);
		return ACC_W'(xe);
	endfunction

	assign waddr = WADDR_W'(dp_cmd.row) * WADDR_W'(MAX_INPUTS) + WADDR_W'(dp_cmd.col);

	// stores: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (dp_cmd.w_we)
			wmem[waddr] <= dp_cmd.data;
		if (dp_cmd.rd)
			w_s1 <= wmem[waddr];
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.a_we)
			amem[dp_cmd.col] <= dp_cmd.data;
		if (dp_cmd.rd)
			a_s1 <= amem[dp_cmd.col];
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			rd_s1 <= dp_cmd.rd;
			rd_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= dp_cmd.first;
		lastk_s1 <= dp_cmd.last_k;
		lastr_s1 <= dp_cmd.last_row;
		row_s1   <= dp_cmd.row;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		lastr_s2 <= lastr_s1;
		row_s2   <= row_s1;
		prod_s2  <= a_s1 * w_s1;
	end

	assign acc_next = first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);
	assign land     = rd_s2 && lastk_s2;

	always_ff @(posedge clk) begin
		if (rd_s2)
			acc_q <= acc_next;
		if (land) begin
			out_acc_q  <= sat(acc_next);
			out_idx_q  <= OIDX_W'(row_s2);
			out_last_q <= lastr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (land)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	assign res.valid       = out_valid_q;
	assign res.accumulator = out_acc_q;
	assign res.out_index   = out_idx_q;
	assign res.last        = out_last_q;

	assign stat.row_done = land;
	assign stat.out_free = !out_valid_q || res.ready;

endmodule
`default_nettype wire

FILE: src/int8_matrix_row_accumulate_unit.sv
// Top level of the int8 matrix row accumulate unit.
// Loads (weight or activation byte) keep the unit idle; ready stays high while idle, so loads go back to back.
// In a run, rows are swept one after another; each row's result is registered once its last
// product is accumulated (one shared MAC, one store read a cycle while a row's sweep issues).
// A row waits in the hold state while the previous result has not been transferred.
// Reset (arst_n low, asynchronous) clears control and sets input_length 256, output_count 64;
// the weight and activation stores are not cleared and hold garbage until written.
`default_nettype none
module int8_matrix_row_accumulate_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	imra_cmd_if.sink                           cmd,
	imra_res_if.source                         res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [imra_pkg::APB_AW-1:0]   paddr,
	input  wire logic [imra_pkg::APB_DW-1:0]   pwdata,
	output logic      [imra_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);
	import imra_pkg::*;

	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	imra_cmd_t        dp_cmd;
	imra_stat_t       stat;

	// Register file. Writes must land only while the unit is idle (a rule for the
	// user; the block itself does not enforce it). The clamped sizes are sampled by
	// the controller at the start of a run and checked against each load as it is accepted.
	imra_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.last_col (last_col),
		.last_row (last_row)
	);

	// Controller: takes one command transfer at a time. Loads become a
	// registered write strobe; a run walks rows in ascending order and,
	// within a row, every column, issuing one store read per cycle.
	imra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.last_col (last_col),
		.last_row (last_row),
		.stat     (stat),
		.dp_cmd   (dp_cmd)
	);

	// Datapath: read stage, multiply stage, accumulate into the result
	// register. The result register decouples the output handshake, so a
	// new command can be taken while the final result of a run still waits.
	imra_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dp_cmd (dp_cmd),
		.res    (res),
		.stat   (stat)
	);

	// A row must never finish into an occupied result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.row_done |-> (!res.valid || res.ready))
		else $error("row result lands on an untaken result");

	// Final row of a run returns the unit to idle.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.row_done && u_dp.lastr_s2) |=> cmd.ready)
		else $error("unit not idle after last row");

	// Store reads only happen inside a run.
	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.rd |-> !cmd.ready)
		else $error("store read issued while idle");

	// At most one store access kind per cycle.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.w_we, dp_cmd.a_we, dp_cmd.rd}))
		else $error("conflicting store accesses");

endmodule
`default_nettype wire
